### hw/rtl/crfw_pkg.sv
// Shared types and constants of the clipped rectangle fill writer.
package crfw_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMD_MUL,
        ST_CMD_CHK,
        ST_ROW_MUL,
        ST_ROW_ADD
    } state_t;

    typedef enum logic [1:0] {
        STATUS_ACCEPTED = 2'd0,
        STATUS_REJECTED = 2'd1,
        STATUS_WRITE    = 2'd2,
        STATUS_IDLE     = 2'd3
    } status_t;

    localparam logic KIND_CMD     = 1'b0;
    localparam logic KIND_ADVANCE = 1'b1;

    localparam logic [1:0] LAYOUT_RGBX    = 2'd0;
    localparam logic [1:0] LAYOUT_BGRX    = 2'd1;
    localparam logic [1:0] LAYOUT_BGR     = 2'd2;
    localparam logic [1:0] LAYOUT_INVALID = 2'd3;

    localparam int CFG_INDEX_BITS = 3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_BASE   = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_BYTES  = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_WIDTH  = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_HEIGHT = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LINE_STRIDE  = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PIXEL_LAYOUT = 3'd5;

    localparam int BYTES_BITS = 32;
    localparam int COLOR_BITS = 24;
    localparam int DATA_BITS  = 32;
    localparam int COUNT_BITS = 3;

    typedef struct packed {
        logic load_cmd;   // latch command, abandon fill
        logic mul;        // register row and area products
        logic cmd_done;   // check command, arm fill, load result
        logic advance;    // emit pixel write, step position
        logic idle_out;   // load idle result
        logic row_addr;   // load next row address
    } cmd_t;

    typedef struct packed {
        logic busy;
        logic row_wrap;
    } stat_t;

endpackage

### hw/rtl/crfw_ctrl.sv
// Controller state machine: sequences command checks, pixel writes and row steps.
module crfw_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic           in_kind,
    output logic           in_stall,
    output logic           out_valid,
    input  logic           out_stall,
    input  crfw_pkg::stat_t stat,
    output crfw_pkg::cmd_t  cmd
);

    crfw_pkg::state_t state_reg;
    crfw_pkg::state_t state_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             in_take;
    logic             out_load;

    assign in_stall  = (state_reg != crfw_pkg::ST_IDLE) || (out_valid_reg && out_stall);
    assign in_take   = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_load  = cmd.advance || cmd.idle_out || cmd.cmd_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= crfw_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        unique case (state_reg)
            crfw_pkg::ST_IDLE:
            begin
                if (in_take)
                begin
                    if (in_kind == crfw_pkg::KIND_CMD)
                    begin
                        cmd.load_cmd = 1'b1;
                        state_next   = crfw_pkg::ST_CMD_MUL;
                    end
                    else if (stat.busy)
                    begin
                        cmd.advance = 1'b1;
                        if (stat.row_wrap)
                        begin
                            state_next = crfw_pkg::ST_ROW_MUL;
                        end
                    end
                    else
                    begin
                        cmd.idle_out = 1'b1;
                    end
                end
            end
            crfw_pkg::ST_CMD_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = crfw_pkg::ST_CMD_CHK;
            end
            crfw_pkg::ST_CMD_CHK:
            begin
                cmd.cmd_done = 1'b1;
                state_next   = crfw_pkg::ST_IDLE;
            end
            crfw_pkg::ST_ROW_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = crfw_pkg::ST_ROW_ADD;
            end
            crfw_pkg::ST_ROW_ADD:
            begin
                cmd.row_addr = 1'b1;
                state_next   = crfw_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = crfw_pkg::ST_IDLE;
            end
        endcase
        out_valid_next = out_load || (out_valid_reg && out_stall);
    end

endmodule

### hw/rtl/crfw_dp.sv
// Datapath: layout registers, fill position, address arithmetic and result register.
module crfw_dp
#(
    parameter int COORD_BITS = 14,
    parameter int ADDR_BITS  = 48
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [crfw_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [ADDR_BITS-1:0]                cfg_data,
    input  logic [COORD_BITS-1:0]               left,
    input  logic [COORD_BITS-1:0]               top,
    input  logic [COORD_BITS-1:0]               rect_width,
    input  logic [COORD_BITS-1:0]               rect_height,
    input  logic [crfw_pkg::COLOR_BITS-1:0]     color,
    input  crfw_pkg::cmd_t                      cmd,
    output crfw_pkg::stat_t                     stat,
    output logic [1:0]                          status,
    output logic [ADDR_BITS-1:0]                write_address,
    output logic [crfw_pkg::DATA_BITS-1:0]      write_data,
    output logic [crfw_pkg::COUNT_BITS-1:0]     byte_count,
    output logic                                last_write
);

    localparam int C      = COORD_BITS;
    localparam int A      = ADDR_BITS;
    localparam int MUL_W  = 2 * C;
    localparam int LIN_W  = 2 * C + 1;
    localparam int OFF_W  = 2 * C + 3;
    localparam int SUM_W  = (A > OFF_W) ? A : OFF_W;
    localparam int CMP_W  = (OFF_W > crfw_pkg::BYTES_BITS) ? OFF_W : crfw_pkg::BYTES_BITS;
    localparam int COL_W  = C + 2;

    // layout registers
    logic [A-1:0]                    frame_base_reg;
    logic [crfw_pkg::BYTES_BITS-1:0] frame_bytes_reg;
    logic [C-1:0]                    frame_width_reg;
    logic [C-1:0]                    frame_height_reg;
    logic [C-1:0]                    line_stride_reg;
    logic [1:0]                      pixel_layout_reg;

    // fill state
    logic                            busy_reg;
    logic [C-1:0]                    cur_col_reg;
    logic [C-1:0]                    cur_row_reg;
    logic [C-1:0]                    start_col_reg;
    logic [C:0]                      end_col_reg;
    logic [C:0]                      end_row_reg;
    logic [crfw_pkg::COLOR_BITS-1:0] fill_color_reg;
    logic [A-1:0]                    row_address_reg;

    // command latch and products
    logic [C-1:0]                    req_w_reg;
    logic [C-1:0]                    req_h_reg;
    logic [crfw_pkg::COLOR_BITS-1:0] req_color_reg;
    logic [MUL_W-1:0]                off_reg;
    logic [MUL_W-1:0]                area_reg;

    // result register
    logic [1:0]                      status_reg;
    logic [A-1:0]                    addr_reg;
    logic [crfw_pkg::DATA_BITS-1:0]  data_reg;
    logic [crfw_pkg::COUNT_BITS-1:0] count_reg;
    logic                            last_reg;

    logic [crfw_pkg::COUNT_BITS-1:0] bpp;
    logic [OFF_W-1:0]                area_ext;
    logic [OFF_W-1:0]                need;
    logic [LIN_W-1:0]                lin;
    logic [OFF_W-1:0]                lin_ext;
    logic [OFF_W-1:0]                off_bytes;
    logic [A-1:0]                    row_addr_calc;
    logic                            layout_ok;
    logic                            cmd_ok;
    logic [C-1:0]                    width_left;
    logic [C-1:0]                    height_left;
    logic [C:0]                      end_col_calc;
    logic [C:0]                      end_row_calc;
    logic [C-1:0]                    col_diff;
    logic [COL_W-1:0]                col_ext;
    logic [COL_W-1:0]                col_bytes;
    logic [A-1:0]                    pix_addr;
    logic [crfw_pkg::DATA_BITS-1:0]  pix_data;
    logic                            col_end;
    logic                            row_end;
    logic [7:0]                      red;
    logic [7:0]                      green;
    logic [7:0]                      blue;

    always_comb
    begin
        unique case (pixel_layout_reg)
            crfw_pkg::LAYOUT_RGBX,
            crfw_pkg::LAYOUT_BGRX:
            begin
                bpp = 3'd4;
            end
            crfw_pkg::LAYOUT_BGR:
            begin
                bpp = 3'd3;
            end
            default:
            begin
                bpp = 3'd0;
            end
        endcase
    end

    // bytes needed by the frame and byte offset of the row start
    always_comb
    begin
        area_ext = OFF_W'(area_reg);
        lin      = LIN_W'(off_reg) + LIN_W'(start_col_reg);
        lin_ext  = OFF_W'(lin);
        unique case (pixel_layout_reg)
            crfw_pkg::LAYOUT_RGBX,
            crfw_pkg::LAYOUT_BGRX:
            begin
                need      = area_ext << 2;
                off_bytes = lin_ext << 2;
            end
            crfw_pkg::LAYOUT_BGR:
            begin
                need      = area_ext + (area_ext << 1);
                off_bytes = lin_ext + (lin_ext << 1);
            end
            default:
            begin
                need      = '0;
                off_bytes = '0;
            end
        endcase
    end

    assign row_addr_calc = A'(SUM_W'(frame_base_reg) + SUM_W'(off_bytes));

    assign layout_ok = (frame_base_reg != '0) && (frame_width_reg != '0)
                    && (frame_height_reg != '0) && (line_stride_reg >= frame_width_reg)
                    && (pixel_layout_reg != crfw_pkg::LAYOUT_INVALID)
                    && (CMP_W'(need) <= CMP_W'(frame_bytes_reg));

    assign cmd_ok = layout_ok && (req_w_reg != '0) && (req_h_reg != '0)
                 && (start_col_reg < frame_width_reg) && (cur_row_reg < frame_height_reg);

    assign width_left   = frame_width_reg - start_col_reg;
    assign height_left  = frame_height_reg - cur_row_reg;
    assign end_col_calc = (req_w_reg > width_left) ? (C+1)'(frame_width_reg)
                        : (C+1)'(start_col_reg) + (C+1)'(req_w_reg);
    assign end_row_calc = (req_h_reg > height_left) ? (C+1)'(frame_height_reg)
                        : (C+1)'(cur_row_reg) + (C+1)'(req_h_reg);

    // pixel write
    assign col_diff = cur_col_reg - start_col_reg;
    assign col_ext  = COL_W'(col_diff);

    always_comb
    begin
        unique case (pixel_layout_reg)
            crfw_pkg::LAYOUT_RGBX,
            crfw_pkg::LAYOUT_BGRX:
            begin
                col_bytes = col_ext << 2;
            end
            crfw_pkg::LAYOUT_BGR:
            begin
                col_bytes = col_ext + (col_ext << 1);
            end
            default:
            begin
                col_bytes = '0;
            end
        endcase
    end

    assign pix_addr = row_address_reg + A'(col_bytes);
    assign red      = fill_color_reg[23:16];
    assign green    = fill_color_reg[15:8];
    assign blue     = fill_color_reg[7:0];

    always_comb
    begin
        unique case (pixel_layout_reg)
            crfw_pkg::LAYOUT_RGBX:
            begin
                pix_data = {8'h00, blue, green, red};
            end
            crfw_pkg::LAYOUT_BGRX,
            crfw_pkg::LAYOUT_BGR:
            begin
                pix_data = {8'h00, red, green, blue};
            end
            default:
            begin
                pix_data = '0;
            end
        endcase
    end

    assign col_end = ((C+1)'(cur_col_reg) + (C+1)'(1)) >= end_col_reg;
    assign row_end = ((C+1)'(cur_row_reg) + (C+1)'(1)) >= end_row_reg;

    assign stat.busy     = busy_reg;
    assign stat.row_wrap = col_end && !row_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_base_reg   <= '0;
            frame_bytes_reg  <= '0;
            frame_width_reg  <= '0;
            frame_height_reg <= '0;
            line_stride_reg  <= '0;
            pixel_layout_reg <= crfw_pkg::LAYOUT_INVALID;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                crfw_pkg::REG_FRAME_BASE:   frame_base_reg   <= cfg_data;
                crfw_pkg::REG_FRAME_BYTES:  frame_bytes_reg  <= cfg_data[crfw_pkg::BYTES_BITS-1:0];
                crfw_pkg::REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[C-1:0];
                crfw_pkg::REG_FRAME_HEIGHT: frame_height_reg <= cfg_data[C-1:0];
                crfw_pkg::REG_LINE_STRIDE:  line_stride_reg  <= cfg_data[C-1:0];
                crfw_pkg::REG_PIXEL_LAYOUT: pixel_layout_reg <= cfg_data[1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg        <= 1'b0;
            cur_col_reg     <= '0;
            cur_row_reg     <= '0;
            start_col_reg   <= '0;
            end_col_reg     <= '0;
            end_row_reg     <= '0;
            fill_color_reg  <= '0;
            row_address_reg <= '0;
        end
        else
        begin
            if (cmd.load_cmd)
            begin
                busy_reg      <= 1'b0;
                cur_col_reg   <= left;
                start_col_reg <= left;
                cur_row_reg   <= top;
            end
            if (cmd.cmd_done && cmd_ok)
            begin
                busy_reg        <= 1'b1;
                end_col_reg     <= end_col_calc;
                end_row_reg     <= end_row_calc;
                fill_color_reg  <= req_color_reg;
                row_address_reg <= row_addr_calc;
            end
            if (cmd.row_addr)
            begin
                row_address_reg <= row_addr_calc;
            end
            if (cmd.advance)
            begin
                if (col_end)
                begin
                    if (row_end)
                    begin
                        busy_reg <= 1'b0;
                    end
                    else
                    begin
                        cur_row_reg <= cur_row_reg + C'(1);
                        cur_col_reg <= start_col_reg;
                    end
                end
                else
                begin
                    cur_col_reg <= cur_col_reg + C'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_cmd)
        begin
            req_w_reg     <= rect_width;
            req_h_reg     <= rect_height;
            req_color_reg <= color;
        end
        if (cmd.mul)
        begin
            off_reg  <= MUL_W'(cur_row_reg) * MUL_W'(line_stride_reg);
            area_reg <= MUL_W'(line_stride_reg) * MUL_W'(frame_height_reg);
        end
        if (cmd.cmd_done)
        begin
            status_reg <= cmd_ok ? crfw_pkg::STATUS_ACCEPTED : crfw_pkg::STATUS_REJECTED;
            addr_reg   <= '0;
            data_reg   <= '0;
            count_reg  <= '0;
            last_reg   <= 1'b0;
        end
        else if (cmd.idle_out)
        begin
            status_reg <= crfw_pkg::STATUS_IDLE;
            addr_reg   <= '0;
            data_reg   <= '0;
            count_reg  <= '0;
            last_reg   <= 1'b0;
        end
        else if (cmd.advance)
        begin
            status_reg <= crfw_pkg::STATUS_WRITE;
            addr_reg   <= pix_addr;
            data_reg   <= pix_data;
            count_reg  <= bpp;
            last_reg   <= col_end && row_end;
        end
    end

    assign status        = status_reg;
    assign write_address = addr_reg;
    assign write_data    = data_reg;
    assign byte_count    = count_reg;
    assign last_write    = last_reg;

endmodule

### hw/rtl/clipped_rect_fill_writer_core.sv
// Top level of the clipped rectangle fill writer: controller plus datapath.
//
// channel  direction  handshake             payload
// in       input      in_valid / in_stall   kind, left, top, rect_width, rect_height, color
// out      output     out_valid / out_stall status, write_address, write_data, byte_count,
//                                           last_write
// cfg      input      cfg_we                cfg_index, cfg_data
//
// Pixel writes within a line and idle advances are taken back to back unless out stalls.
// An advance that ends any line but the last fetches the next line address through the
// row multiplier in ST_ROW_MUL, ST_ROW_ADD; a command forms products, then is checked.
// One result register separates the sides; in_stall rises while it is stalled or outside ST_IDLE.
// rst_n clears the controller, fill state and layout registers asynchronously.
module clipped_rect_fill_writer_core
#(
    parameter int COORD_BITS = 14,
    parameter int ADDR_BITS  = 48
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [crfw_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [ADDR_BITS-1:0]                cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                kind,
    input  logic [COORD_BITS-1:0]               left,
    input  logic [COORD_BITS-1:0]               top,
    input  logic [COORD_BITS-1:0]               rect_width,
    input  logic [COORD_BITS-1:0]               rect_height,
    input  logic [crfw_pkg::COLOR_BITS-1:0]     color,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [1:0]                          status,
    output logic [ADDR_BITS-1:0]                write_address,
    output logic [crfw_pkg::DATA_BITS-1:0]      write_data,
    output logic [crfw_pkg::COUNT_BITS-1:0]     byte_count,
    output logic                                last_write
);

    crfw_pkg::cmd_t  cmd;
    crfw_pkg::stat_t stat;

    crfw_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_kind   (kind),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    crfw_dp
    #(
        .COORD_BITS (COORD_BITS),
        .ADDR_BITS  (ADDR_BITS)
    )
    u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .left          (left),
        .top           (top),
        .rect_width    (rect_width),
        .rect_height   (rect_height),
        .color         (color),
        .cmd           (cmd),
        .stat          (stat),
        .status        (status),
        .write_address (write_address),
        .write_data    (write_data),
        .byte_count    (byte_count),
        .last_write    (last_write)
    );

    a_cmd_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && kind == crfw_pkg::KIND_CMD |=> in_stall)
        else $error("input not held during command check");

    a_cmd_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && kind == crfw_pkg::KIND_CMD |-> ##3
        out_valid && (status == crfw_pkg::STATUS_ACCEPTED
                      || status == crfw_pkg::STATUS_REJECTED))
        else $error("command result missing");

    a_adv_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && kind == crfw_pkg::KIND_ADVANCE |=>
        out_valid && (status == crfw_pkg::STATUS_WRITE || status == crfw_pkg::STATUS_IDLE))
        else $error("advance result missing");

endmodule
